/* src/des_pkg.sv */
// Shared constants and types for the delta escape sample decoder.
package des_pkg;

  localparam int unsigned BYTE_BITS     = 8;
  localparam int unsigned SAMPLE_BITS   = 2 * BYTE_BITS;
  localparam int unsigned COUNT_BITS    = 16;
  localparam logic [BYTE_BITS-1:0] ESCAPE_BYTE = 8'h80;
  localparam logic [COUNT_BITS-1:0] CAPACITY_RESET = 16'd256;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          sample_valid;
    logic                          packet_done;
    logic [COUNT_BITS-1:0]         sample_count;
  } result_t;

endpackage

/* src/des_if.sv */
// Valid/ready channel interfaces for bytes in, results out and the capacity register.
interface des_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface des_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               sample_valid;
  logic               packet_done;
  logic [15:0]        sample_count;

  modport source (output valid, output sample, output sample_valid, output packet_done,
                  output sample_count, input ready);
  modport sink (input valid, input sample, input sample_valid, input packet_done,
                input sample_count, output ready);
endinterface

interface des_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink (input valid, input capacity, output ready);
endinterface

/* src/des_decode.sv */
// Input byte register, packet decode state and the per-byte decode logic.
module des_decode (
  input  logic                  clk,
  input  logic                  rst,
  des_in_if.sink                in_ch,
  des_cfg_if.sink               cfg,
  input  logic                  q_ready,
  output logic                  res_valid,
  output des_pkg::result_t      res
);
  import des_pkg::*;

  typedef enum logic [2:0] {
    PH_FIRST_HI,
    PH_FIRST_LO,
    PH_DELTA,
    PH_ESC_HI,
    PH_ESC_LO
  } phase_t;

  // input register
  logic                   byte_valid;
  logic [BYTE_BITS-1:0]   byte_reg;
  logic                   last_reg;

  // packet state
  phase_t                 phase, phase_next;
  logic [SAMPLE_BITS-1:0] previous_sample;
  logic [BYTE_BITS-1:0]   held_high_byte, held_high_byte_next;
  logic [COUNT_BITS-1:0]  decoded_count, decoded_count_next;
  logic [COUNT_BITS-1:0]  capacity;

  logic                   got;
  logic [SAMPLE_BITS-1:0] s;
  logic                   emit;
  logic                   fire;

  always_comb begin
    got                 = 1'b0;
    s                   = previous_sample;
    phase_next          = phase;
    held_high_byte_next = held_high_byte;
    if (decoded_count < capacity) begin
      unique case (phase)
        PH_FIRST_HI: begin
          held_high_byte_next = byte_reg;
          phase_next          = PH_FIRST_LO;
        end
        PH_FIRST_LO: begin
          s          = {held_high_byte, byte_reg};
          got        = 1'b1;
          phase_next = PH_DELTA;
        end
        PH_DELTA: begin
          if (byte_reg == ESCAPE_BYTE) begin
            phase_next = PH_ESC_HI;
          end else begin
            s   = previous_sample + {{BYTE_BITS{byte_reg[BYTE_BITS-1]}}, byte_reg};
            got = 1'b1;
          end
        end
        PH_ESC_HI: begin
          held_high_byte_next = byte_reg;
          phase_next          = PH_ESC_LO;
        end
        PH_ESC_LO: begin
          s          = {held_high_byte, byte_reg};
          got        = 1'b1;
          phase_next = PH_DELTA;
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
    decoded_count_next = got ? decoded_count + 1'b1 : decoded_count;
  end

  assign emit      = got | last_reg;
  assign fire      = byte_valid & (~emit | q_ready);
  assign res_valid = byte_valid & emit & q_ready;

  assign res.sample       = got ? $signed(s) : '0;
  assign res.sample_valid = got;
  assign res.packet_done  = last_reg;
  assign res.sample_count = decoded_count_next;

  assign in_ch.ready = ~byte_valid | fire;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid      <= 1'b0;
      phase           <= PH_FIRST_HI;
      previous_sample <= '0;
      held_high_byte  <= '0;
      decoded_count   <= '0;
      capacity        <= CAPACITY_RESET;
    end else begin
      if (cfg.valid) begin
        capacity <= cfg.capacity;
      end
      if (in_ch.valid && in_ch.ready) begin
        byte_valid <= 1'b1;
      end else if (fire) begin
        byte_valid <= 1'b0;
      end
      if (fire) begin
        if (last_reg) begin
          phase           <= PH_FIRST_HI;
          previous_sample <= '0;
          held_high_byte  <= '0;
          decoded_count   <= '0;
        end else begin
          phase          <= phase_next;
          held_high_byte <= held_high_byte_next;
          decoded_count  <= decoded_count_next;
          if (got) begin
            previous_sample <= s;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_reg <= in_ch.data_byte;
      last_reg <= in_ch.last_byte;
    end
  end

endmodule

/* src/des_out_q.sv */
// Two-entry result queue that decouples the decoder from the output stall.
module des_out_q (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  input  des_pkg::result_t res,
  output logic             q_ready,
  des_out_if.source        out_ch
);
  import des_pkg::*;

  result_t     mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        push;
  logic        pop;

  assign q_ready = (fill != 2'd2);
  assign push    = res_valid;
  assign pop     = out_ch.valid & out_ch.ready;

  assign out_ch.valid        = (fill != 2'd0);
  assign out_ch.sample       = mem[rd_ptr].sample;
  assign out_ch.sample_valid = mem[rd_ptr].sample_valid;
  assign out_ch.packet_done  = mem[rd_ptr].packet_done;
  assign out_ch.sample_count = mem[rd_ptr].sample_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= res;
    end
  end

endmodule

/* src/delta_escape_sample_decoder.sv */
// Top level of the delta escape sample decoder: byte register, decoder and result queue.
// An accepted byte is held in the byte register and decoded, and its result, if any, is
// written into a queue entry, from which out_ch presents it.
// Throughput: one byte per cycle if the queue has room, bound by the decode add and select.
// The two-entry queue keeps input ready combinationally independent of out_ch.ready.
// Reset (rst, synchronous, active high): capacity returns to 256, packet state to the
// first high byte with sample, held byte and count zero, and both channels empty.
module delta_escape_sample_decoder (
  input  logic      clk,
  input  logic      rst,
  des_in_if.sink    in_ch,
  des_cfg_if.sink   cfg,
  des_out_if.source out_ch
);
  import des_pkg::*;

  // decode stage request into the queue
  logic    res_valid;
  result_t res;
  logic    q_ready;

  // Register each byte, decode it against the packet state, and advance the state only
  // when the result (if any) has room in the queue.
  des_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .q_ready   (q_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  // Hold up to two results while the consumer stalls; the full flag is registered state.
  des_out_q u_out_q (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .q_ready   (q_ready),
    .out_ch    (out_ch)
  );

endmodule
